@@ rtl/partial_interval_tree_walker_core_defines.svh @@
// Assertion macros shared by the interval tree walker RTL.
`ifndef PARTIAL_INTERVAL_TREE_WALKER_CORE_DEFINES_SVH
`define PARTIAL_INTERVAL_TREE_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PITW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PITW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pitw_pkg.sv @@
// Shared types and constants of the interval tree walker.
package pitw_pkg;

    localparam int START_W = 33;
    localparam int LEN_W   = 34;
    localparam int LOG_W   = 6;
    localparam int LEAF_W  = 5;
    localparam int CNT_W_E = 33;
    localparam int DATA_W  = 33;
    localparam logic [LOG_W-1:0] TOP_LOG = 6'd33;

    localparam logic [1:0] ST_NODE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [1:0] CFG_LEAF_LOG = 2'd0;
    localparam logic [1:0] CFG_ROOT_LOG = 2'd1;
    localparam logic [1:0] CFG_ELEM_CNT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK
    } t_state;

    typedef struct packed {
        logic       rewind;
        logic       clear_cnt;
        logic       step;
        logic       finish;
        logic       emit;
        logic [1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic pre_done;
        logic pre_error;
        logic finished;
        logic visit;
        logic top;
        logic runaway;
    } t_stat;

endpackage

@@ rtl/pitw_ctrl.sv @@
// Controller state machine of the interval tree walker.
module pitw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_restart,
    input  pitw_pkg::t_stat i_stat,
    output pitw_pkg::t_cmd  o_cmd,
    output logic          busy
);
    import pitw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.rewind    = i_restart;
                    o_cmd.clear_cnt = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.pre_done) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    n_state           = S_IDLE;
                end else if (i_stat.pre_error) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_ERROR;
                    n_state           = S_IDLE;
                end else if (i_stat.finished) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_stat.runaway) begin
                    o_cmd.finish      = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    n_state           = S_IDLE;
                end else if (i_stat.visit) begin
                    o_cmd.step        = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_NODE;
                    n_state           = S_IDLE;
                end else if (i_stat.top) begin
                    o_cmd.step        = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_DONE;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/pitw_datapath.sv @@
// Config registers, walk cursor, phase step logic and result registers.
module pitw_datapath #(
    parameter int MAX_ROOT_LOG = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [pitw_pkg::DATA_W-1:0]   i_cfg_data,
    input  pitw_pkg::t_cmd                i_cmd,
    output pitw_pkg::t_stat               o_stat,
    output logic                          o_result_valid,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_node_start,
    output logic [32:0]                   o_node_length,
    output logic [5:0]                    o_node_log
);
    import pitw_pkg::*;

    localparam int STEP_LIMIT = 4 * (MAX_ROOT_LOG + 1);
    localparam int CNT_W      = $clog2(STEP_LIMIT + 1);

    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_UP    = 2'd2;

    logic [LEAF_W-1:0]  r_leaf_log,  n_leaf_log;
    logic [LOG_W-1:0]   r_root_log,  n_root_log;
    logic [CNT_W_E-1:0] r_elem_cnt,  n_elem_cnt;
    logic [START_W-1:0] r_start,     n_start;
    logic [LOG_W-1:0]   r_log,       n_log;
    logic [1:0]         r_phase,     n_phase;
    logic               r_finished,  n_finished;
    logic [CNT_W-1:0]   r_cnt,       n_cnt;
    logic               r_valid;
    logic [1:0]         r_status;
    logic [31:0]        r_node_start;
    logic [32:0]        r_node_length;
    logic [5:0]         r_node_log;

    logic               cfg_hit;
    logic [LEN_W-1:0]   full_len, half_len;
    logic [LEN_W-1:0]   ec_x, start_x, len, avail, vis_len, end_pos, right_pos;
    logic               is_right;

    // Consistency checks on the config, cursor status
    always_comb begin
        full_len = LEN_W'(1) << r_root_log;
        half_len = full_len >> 1;
        ec_x     = {1'b0, r_elem_cnt};
        o_stat.pre_done  = (r_root_log <= {1'b0, r_leaf_log}) || (r_elem_cnt == '0);
        o_stat.pre_error = (r_root_log > LOG_W'(MAX_ROOT_LOG)) || (r_root_log > TOP_LOG)
                           || (ec_x > full_len) || (ec_x <= half_len);
        start_x   = {1'b0, r_start};
        len       = LEN_W'(1) << r_log;
        is_right  = |(start_x & len);
        avail     = (ec_x > start_x) ? (ec_x - start_x) : '0;
        vis_len   = (avail < len) ? avail : len;
        end_pos   = start_x + len;
        right_pos = start_x + (len >> 1);
        o_stat.finished = r_finished;
        o_stat.visit    = (r_phase == PH_ENTER);
        o_stat.top      = (r_phase != PH_ENTER) && (r_phase != PH_LEFT)
                          && (r_log >= r_root_log);
        o_stat.runaway  = (r_cnt == CNT_W'(STEP_LIMIT));
    end

    always_comb begin
        n_leaf_log = r_leaf_log;
        n_root_log = r_root_log;
        n_elem_cnt = r_elem_cnt;
        n_start    = r_start;
        n_log      = r_log;
        n_phase    = r_phase;
        n_finished = r_finished;
        n_cnt      = r_cnt;
        cfg_hit    = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEAF_LOG: begin
                    n_leaf_log = i_cfg_data[LEAF_W-1:0];
                    cfg_hit    = 1'b1;
                end
                CFG_ROOT_LOG: begin
                    n_root_log = i_cfg_data[LOG_W-1:0];
                    cfg_hit    = 1'b1;
                end
                CFG_ELEM_CNT: begin
                    n_elem_cnt = i_cfg_data[CNT_W_E-1:0];
                    cfg_hit    = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        if (i_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
            unique case (r_phase)
                PH_ENTER: begin
                    priority if ({1'b0, r_log} > ({2'b0, r_leaf_log} + 7'd1)) begin
                        n_log = r_log - 1'b1;
                    end else if (r_log == r_root_log) begin
                        n_finished = 1'b1;
                    end else if (is_right || (end_pos >= ec_x)) begin
                        if (is_right) begin
                            n_start = START_W'(start_x - len);
                        end
                        n_log   = r_log + 1'b1;
                        n_phase = PH_UP;
                    end else begin
                        n_start = START_W'(end_pos);
                    end
                end
                PH_LEFT: begin
                    if (right_pos < ec_x) begin
                        n_log   = r_log - 1'b1;
                        n_start = START_W'(right_pos);
                        n_phase = PH_ENTER;
                    end else begin
                        n_phase = PH_UP;
                    end
                end
                default: begin
                    if (r_log >= r_root_log) begin
                        n_finished = 1'b1;
                    end else begin
                        if (is_right) begin
                            n_start = START_W'(start_x - len);
                            n_phase = PH_UP;
                        end else begin
                            n_phase = PH_LEFT;
                        end
                        n_log = r_log + 1'b1;
                    end
                end
            endcase
        end
        if (i_cmd.finish) begin
            n_finished = 1'b1;
        end
        if (i_cmd.clear_cnt) begin
            n_cnt = '0;
        end
        if (i_cmd.rewind || cfg_hit) begin
            n_start    = '0;
            n_log      = n_root_log;
            n_phase    = PH_ENTER;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_log <= '0;
            r_root_log <= LOG_W'(1);
            r_elem_cnt <= CNT_W_E'(2);
            r_start    <= '0;
            r_log      <= LOG_W'(1);
            r_phase    <= PH_ENTER;
            r_finished <= 1'b0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_leaf_log <= n_leaf_log;
            r_root_log <= n_root_log;
            r_elem_cnt <= n_elem_cnt;
            r_start    <= n_start;
            r_log      <= n_log;
            r_phase    <= n_phase;
            r_finished <= n_finished;
            r_cnt      <= n_cnt;
            r_valid    <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            if (i_cmd.emit_status == ST_NODE) begin
                r_node_start  <= r_start[31:0];
                r_node_length <= vis_len[32:0];
                r_node_log    <= r_log;
            end else begin
                r_node_start  <= '0;
                r_node_length <= '0;
                r_node_log    <= '0;
            end
        end
    end

    assign o_result_valid = r_valid;
    assign o_status       = r_status;
    assign o_node_start   = r_node_start;
    assign o_node_length  = r_node_length;
    assign o_node_log     = r_node_log;

endmodule

@@ rtl/partial_interval_tree_walker_core.sv @@
// Top level of the depth-first interval tree walker.
// Each start transfer (i_restart high rewinds to the root first) yields exactly one
// result, shown for one cycle with o_result_valid; the receiver cannot stall it, so
// it must take the result in that cycle. A done or error answer that is decided
// before any walking (walk already finished, no node above leaf level, no elements,
// bad root log or count) comes from the check state. Any other answer comes from the
// walk state, which steps the walker's phase until it enters a node (node answer),
// reaches the top or hits the step limit (done); going down enters a node at the first
// step, climbing back from a leaf takes up to two phase steps per level. busy is high
// from the start transfer until the result is shown; config writes only while busy is low.
`include "partial_interval_tree_walker_core_defines.svh"
module partial_interval_tree_walker_core #(
    parameter int MAX_ROOT_LOG = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data,
    input  logic        start,
    input  logic        i_restart,
    output logic        busy,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_node_start,
    output logic [32:0] o_node_length,
    output logic [5:0]  o_node_log
);
    import pitw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pitw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_restart (i_restart),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    pitw_datapath #(
        .MAX_ROOT_LOG (MAX_ROOT_LOG)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_node_start   (o_node_start),
        .o_node_length  (o_node_length),
        .o_node_log     (o_node_log)
    );

    `PITW_ASSERT_NOW(a_valid_idle, o_result_valid, !busy, "result shown while busy")
    `PITW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "start transfer did not set busy")
    `PITW_ASSERT_NEXT(a_single_pulse, o_result_valid, !o_result_valid, "result held two cycles")
    `PITW_ASSERT_NOW(a_status_code, o_result_valid, (o_status == ST_NODE) || (o_status == ST_DONE) || (o_status == ST_ERROR), "bad status code")
    `PITW_ASSERT_NOW(a_zero_fields, o_result_valid && (o_status != ST_NODE), (o_node_start == '0) && (o_node_length == '0) && (o_node_log == '0), "non-node result carries data")

endmodule
